>>> hdl/met_pkg.sv
// shared constants, types and state encoding for the escape-time unit
package met_pkg;

   localparam int IN_WIDTH        = 32;
   localparam int IN_FRAC         = 28;
   localparam int Z_INT_BITS      = 12;
   localparam int BOUND_WIDTH     = 32;
   localparam int BOUND_FRAC      = 24;
   localparam int MAX_ITER_WIDTH  = 16;
   localparam int STEP_WIDTH      = 16;
   localparam int CSR_INDEX_WIDTH = 8;
   localparam int CSR_DATA_WIDTH  = 32;
   localparam int DEF_ITER_WIDTH  = 16;
   localparam int DEF_FRAC_BITS   = 28;

   localparam logic [MAX_ITER_WIDTH-1:0] MAX_ITER_RESET = 16'd256;
   localparam logic [BOUND_WIDTH-1:0]    BOUND_RESET    = 32'h0400_0000;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_ITER_LIMIT   = 8'd0,
      CSR_ESCAPE_BOUND = 8'd1
   } met_csr_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MAG,
      ST_MUL,
      ST_SUM,
      ST_UPD
   } met_state_type;

   typedef struct packed {
      logic       load_c;
      logic       mag_en;
      logic       mul_en;
      logic [1:0] mul_phase;
      logic       sum_en;
      logic       upd_en;
   } met_cmd_type;

endpackage

>>> hdl/mandelbrot_escape_time_unit.sv
// Mandelbrot escape-time unit: one point c per start, one result strobe per point.
// A point is taken when start is high and busy is low. The orbit z = z*z + c runs
// one step per pass of states: magnitude load, multiply phases (each 40-bit square
// and cross product is built from four half-width partial products on three
// multipliers), sum/compare and update. A point whose orbit first escapes at step
// s reports it with rsp_escape_step = s; with an iteration limit of L a point
// that never escapes in L steps reports not escaped with a zero step, and a
// limit of zero answers on the cycle after the accept. The result is on rsp_* for
// exactly one cycle with rsp_valid high and cannot be held off; busy is already
// low in that cycle so the next point may be started at once. Configuration
// writes are taken every cycle (csr_ready stays high) and must only be issued
// while the unit is idle.
module mandelbrot_escape_time_unit #(
   parameter int ITER_WIDTH = met_pkg::DEF_ITER_WIDTH,
   parameter int FRAC_BITS  = met_pkg::DEF_FRAC_BITS
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   start,
   output logic                                   busy,
   input  logic signed [met_pkg::IN_WIDTH-1:0]    req_c_real,
   input  logic signed [met_pkg::IN_WIDTH-1:0]    req_c_imag,
   output logic                                   rsp_valid,
   output logic                                   rsp_escaped,
   output logic [met_pkg::STEP_WIDTH-1:0]         rsp_escape_step,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [met_pkg::CSR_INDEX_WIDTH-1:0]    csr_index,
   input  logic [met_pkg::CSR_DATA_WIDTH-1:0]     csr_wdata
);
   import met_pkg::*;

   logic [MAX_ITER_WIDTH-1:0] max_iter_ff, max_iter_in;
   logic [BOUND_WIDTH-1:0]    bound_ff, bound_in;
   logic [ITER_WIDTH-1:0]     limit;
   met_cmd_type               cmd;
   logic                      mod_gt;

   assign csr_ready = 1'b1;

   always_comb begin
      max_iter_in = max_iter_ff;
      bound_in    = bound_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_ITER_LIMIT:   max_iter_in = csr_wdata[MAX_ITER_WIDTH-1:0];
            CSR_ESCAPE_BOUND: bound_in    = csr_wdata[BOUND_WIDTH-1:0];
            default:          max_iter_in = max_iter_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_iter_ff <= MAX_ITER_RESET;
         bound_ff    <= BOUND_RESET;
      end else begin
         max_iter_ff <= max_iter_in;
         bound_ff    <= bound_in;
      end
   end

   assign limit = ITER_WIDTH'(max_iter_ff);

   met_ctrl #(
      .ITER_WIDTH (ITER_WIDTH)
   ) u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .limit           (limit),
      .mod_gt          (mod_gt),
      .cmd             (cmd),
      .rsp_valid       (rsp_valid),
      .rsp_escaped     (rsp_escaped),
      .rsp_escape_step (rsp_escape_step)
   );

   met_datapath #(
      .FRAC_BITS (FRAC_BITS)
   ) u_datapath (
      .clock        (clock),
      .c_real       (req_c_real),
      .c_imag       (req_c_imag),
      .escape_bound (bound_ff),
      .cmd          (cmd),
      .mod_gt       (mod_gt)
   );

endmodule

>>> hdl/met_datapath.sv
// escape-time datapath: z registers, split multiplier, update and bound compare
module met_datapath #(
   parameter int FRAC_BITS = met_pkg::DEF_FRAC_BITS
) (
   input  logic                                     clock,
   input  logic signed [met_pkg::IN_WIDTH-1:0]      c_real,
   input  logic signed [met_pkg::IN_WIDTH-1:0]      c_imag,
   input  logic        [met_pkg::BOUND_WIDTH-1:0]   escape_bound,
   input  met_pkg::met_cmd_type                     cmd,
   output logic                                     mod_gt
);
   import met_pkg::*;

   localparam int ZW  = FRAC_BITS + Z_INT_BITS;
   localparam int H   = (ZW + 1) / 2;
   localparam int PW  = 2 * ZW;
   localparam int DW  = PW + 1;
   localparam int SW  = DW + 1;
   localparam int BSH = 2 * FRAC_BITS - BOUND_FRAC;
   localparam int UP  = (FRAC_BITS >= IN_FRAC) ? FRAC_BITS - IN_FRAC : 0;
   localparam int DN  = (FRAC_BITS < IN_FRAC) ? IN_FRAC - FRAC_BITS : 0;
   localparam int CXW = (IN_WIDTH + UP > ZW) ? IN_WIDTH + UP : ZW;

   localparam logic signed [ZW-1:0] Z_MAX = {1'b0, {(ZW-1){1'b1}}};
   localparam logic signed [ZW-1:0] Z_MIN = {1'b1, {(ZW-1){1'b0}}};

   function automatic logic signed [ZW-1:0] scale_c(input logic signed [IN_WIDTH-1:0] v);
      logic signed [CXW-1:0] w;
      w = CXW'(v);
      w = (w <<< UP) >>> DN;
      return ZW'(w);
   endfunction

   function automatic logic [ZW-1:0] mag(input logic signed [ZW-1:0] v);
      logic signed [ZW-1:0] n;
      n = -v;
      return v[ZW-1] ? unsigned'(n) : unsigned'(v);
   endfunction

   function automatic logic [H-1:0] pick(input logic [ZW-1:0] a, input logic upper);
      logic [ZW-1:0] s;
      s = a >> H;
      return upper ? H'(s) : a[H-1:0];
   endfunction

   function automatic logic [PW-1:0] place(input logic [2*H-1:0] pp, input logic [1:0] ph);
      logic [PW-1:0] x;
      x = PW'(pp);
      if (ph[1] && ph[0]) begin
         return x << (2 * H);
      end else if (ph[1] || ph[0]) begin
         return x << H;
      end else begin
         return x;
      end
   endfunction

   function automatic logic signed [ZW-1:0] sat(input logic signed [SW-1:0] v);
      logic signed [SW-1:0] t;
      t = SW'(v[ZW-1:0] );
      t = SW'(signed'(v[ZW-1:0]));
      if (t == v) begin
         return v[ZW-1:0];
      end else if (v[SW-1]) begin
         return Z_MIN;
      end else begin
         return Z_MAX;
      end
   endfunction

   logic signed [ZW-1:0] cr_ff, cr_in, ci_ff, ci_in;
   logic signed [ZW-1:0] zr_ff, zr_in, zi_ff, zi_in;
   logic        [ZW-1:0] ar_ff, ar_in, ai_ff, ai_in;
   logic                 neg_ff, neg_in;
   logic        [PW-1:0] acc_rr_ff, acc_rr_in, acc_ii_ff, acc_ii_in, acc_ri_ff, acc_ri_in;
   logic signed [DW-1:0] diff_ff, diff_in, ri_s_ff, ri_s_in;
   logic                 mod_gt_ff, mod_gt_in;

   logic [2*H-1:0]       pp_rr, pp_ii, pp_ri;
   logic [DW-1:0]        rr_x, ii_x, modulus, bound_scaled;
   logic signed [DW-1:0] ri_x, nr_fl, ni_fl;
   logic signed [SW-1:0] sum_r, sum_i;

   // one quarter of each 3 products per cycle, lo/hi halves of the magnitudes
   always_comb begin
      pp_rr = pick(ar_ff, cmd.mul_phase[1]) * pick(ar_ff, cmd.mul_phase[0]);
      pp_ii = pick(ai_ff, cmd.mul_phase[1]) * pick(ai_ff, cmd.mul_phase[0]);
      pp_ri = pick(ar_ff, cmd.mul_phase[1]) * pick(ai_ff, cmd.mul_phase[0]);
   end

   always_comb begin
      rr_x         = {1'b0, acc_rr_ff};
      ii_x         = {1'b0, acc_ii_ff};
      ri_x         = signed'({1'b0, acc_ri_ff});
      modulus      = rr_x + ii_x;
      bound_scaled = DW'(escape_bound) << BSH;
      // 2*zr*zi floored to the z scale is the product floored one bit less
      nr_fl        = diff_ff >>> FRAC_BITS;
      ni_fl        = ri_s_ff >>> (FRAC_BITS - 1);
      sum_r        = SW'(nr_fl) + SW'(cr_ff);
      sum_i        = SW'(ni_fl) + SW'(ci_ff);
   end

   always_comb begin
      cr_in     = cr_ff;
      ci_in     = ci_ff;
      zr_in     = zr_ff;
      zi_in     = zi_ff;
      ar_in     = ar_ff;
      ai_in     = ai_ff;
      neg_in    = neg_ff;
      acc_rr_in = acc_rr_ff;
      acc_ii_in = acc_ii_ff;
      acc_ri_in = acc_ri_ff;
      diff_in   = diff_ff;
      ri_s_in   = ri_s_ff;
      mod_gt_in = mod_gt_ff;
      if (cmd.load_c) begin
         cr_in = scale_c(c_real);
         ci_in = scale_c(c_imag);
         zr_in = '0;
         zi_in = '0;
      end
      if (cmd.mag_en) begin
         ar_in     = mag(zr_ff);
         ai_in     = mag(zi_ff);
         neg_in    = zr_ff[ZW-1] ^ zi_ff[ZW-1];
         acc_rr_in = '0;
         acc_ii_in = '0;
         acc_ri_in = '0;
      end
      if (cmd.mul_en) begin
         acc_rr_in = acc_rr_ff + place(pp_rr, cmd.mul_phase);
         acc_ii_in = acc_ii_ff + place(pp_ii, cmd.mul_phase);
         acc_ri_in = acc_ri_ff + place(pp_ri, cmd.mul_phase);
      end
      if (cmd.sum_en) begin
         diff_in   = signed'(rr_x) - signed'(ii_x);
         ri_s_in   = neg_ff ? -ri_x : ri_x;
         // squares of the current z give |z|^2 of the step that produced it
         mod_gt_in = modulus > bound_scaled;
      end
      if (cmd.upd_en) begin
         zr_in = sat(sum_r);
         zi_in = sat(sum_i);
      end
   end

   always_ff @(posedge clock) begin
      cr_ff     <= cr_in;
      ci_ff     <= ci_in;
      zr_ff     <= zr_in;
      zi_ff     <= zi_in;
      ar_ff     <= ar_in;
      ai_ff     <= ai_in;
      neg_ff    <= neg_in;
      acc_rr_ff <= acc_rr_in;
      acc_ii_ff <= acc_ii_in;
      acc_ri_ff <= acc_ri_in;
      diff_ff   <= diff_in;
      ri_s_ff   <= ri_s_in;
      mod_gt_ff <= mod_gt_in;
   end

   assign mod_gt = mod_gt_ff;

endmodule

>>> hdl/met_ctrl.sv
// escape-time controller: iteration sequencer, step counter and result register
module met_ctrl #(
   parameter int ITER_WIDTH = met_pkg::DEF_ITER_WIDTH
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic [ITER_WIDTH-1:0]              limit,
   input  logic                               mod_gt,
   output met_pkg::met_cmd_type               cmd,
   output logic                               rsp_valid,
   output logic                               rsp_escaped,
   output logic [met_pkg::STEP_WIDTH-1:0]     rsp_escape_step
);
   import met_pkg::*;

   met_state_type         state_ff, state_in;
   logic [1:0]            phase_ff, phase_in;
   logic [ITER_WIDTH-1:0] step_ff, step_in;
   logic                  have_z_ff, have_z_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_escaped_ff, rsp_escaped_in;
   logic [STEP_WIDTH-1:0] rsp_step_ff, rsp_step_in;

   logic accept;
   logic last_step;
   logic zero_limit;

   assign accept     = (state_ff == ST_IDLE) && start;
   assign zero_limit = (limit == '0);
   assign last_step  = ({1'b0, step_ff} + 1'b1) == {1'b0, limit};

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start && !zero_limit) begin
               state_in = ST_MAG;
            end
         end
         ST_MAG: begin
            state_in = ST_MUL;
         end
         ST_MUL: begin
            if (phase_ff == 2'b11) begin
               state_in = ST_SUM;
            end
         end
         ST_SUM: begin
            state_in = ST_UPD;
         end
         ST_UPD: begin
            if (have_z_ff && (mod_gt || last_step)) begin
               state_in = ST_IDLE;
            end else begin
               state_in = ST_MAG;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd           = '0;
      cmd.load_c    = accept;
      cmd.mul_phase = phase_ff;
      case (state_ff)
         ST_IDLE: cmd.load_c = accept;
         ST_MAG:  cmd.mag_en = 1'b1;
         ST_MUL:  cmd.mul_en = 1'b1;
         ST_SUM:  cmd.sum_en = 1'b1;
         ST_UPD:  cmd.upd_en = 1'b1;
         default: cmd        = '0;
      endcase
   end

   always_comb begin
      phase_in       = (state_ff == ST_MUL) ? phase_ff + 2'b01 : 2'b00;
      step_in        = step_ff;
      have_z_in      = have_z_ff;
      rsp_valid_in   = 1'b0;
      rsp_escaped_in = 1'b0;
      rsp_step_in    = '0;
      if (accept) begin
         step_in   = '0;
         have_z_in = 1'b0;
         if (zero_limit) begin
            rsp_valid_in = 1'b1;
         end
      end
      if (state_ff == ST_UPD) begin
         have_z_in = 1'b1;
         // the first pass only builds z for step zero
         if (have_z_ff) begin
            if (mod_gt) begin
               rsp_valid_in   = 1'b1;
               rsp_escaped_in = 1'b1;
               rsp_step_in    = STEP_WIDTH'(step_ff);
            end else if (last_step) begin
               rsp_valid_in = 1'b1;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         phase_ff       <= 2'b00;
         step_ff        <= '0;
         have_z_ff      <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         rsp_escaped_ff <= 1'b0;
         rsp_step_ff    <= '0;
      end else begin
         state_ff       <= state_in;
         phase_ff       <= phase_in;
         step_ff        <= step_in;
         have_z_ff      <= have_z_in;
         rsp_valid_ff   <= rsp_valid_in;
         rsp_escaped_ff <= rsp_escaped_in;
         rsp_step_ff    <= rsp_step_in;
      end
   end

   assign busy            = (state_ff != ST_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_escaped     = rsp_escaped_ff;
   assign rsp_escape_step = rsp_step_ff;

   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ($past(state_ff) == ST_UPD || $past(state_ff) == ST_IDLE))
      else $error("result strobe not preceded by update or accept");

   a_first_pass: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_UPD && !have_z_ff) |=> (state_ff == ST_MAG && !rsp_valid_ff))
      else $error("first pass produced a result");

   a_no_escape_step: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_escaped_ff) |-> (rsp_step_ff == '0))
      else $error("non-escaped result carries a step");

   a_accept_progress: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (busy || rsp_valid_ff))
      else $error("accepted transaction neither started nor answered");

   a_phase_in_mul: assert property (@(posedge clock) disable iff (reset)
      (phase_ff != 2'b00) |-> (state_ff == ST_MUL))
      else $error("multiply phase outside multiply state");

endmodule
